// ----- rtl/mf_pkg.sv -----
// Shared types and constants for the 5x5 median filter.
// No dependencies; every other file imports this package.
`default_nettype none
package mf_pkg;

  localparam int PIX_W         = 8;
  localparam int LW_W          = 12;
  localparam int FH_W          = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_WIN_SIZE  = 5;
  localparam int OUT_FIFO_D    = 16;

  localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // control that travels with an item down the select chain
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic             last;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/mf_line_store.sv -----
// One line store: simple dual-port RAM, registered read.
// Depends on mf_pkg for the pixel width.
`default_nettype none
module mf_line_store
  import mf_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [PIX_W-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [PIX_W-1:0] wr_data
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mf_select_cell.sv -----
// One cell of the radix-select chain: settles one result bit, MSB first.
// Depends on mf_pkg (ctl_t, PIX_W).
`default_nettype none
module mf_select_cell
  import mf_pkg::*;
#(
  parameter int TAPS = 25,
  parameter int KW   = 5,
  parameter int BIT  = 7
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ctl_t                       in_ctl,
  input  wire logic [TAPS-1:0][PIX_W-1:0] in_vals,
  input  wire logic [TAPS-1:0]            in_mask,
  input  wire logic [KW-1:0]              in_k,
  input  wire logic [PIX_W-1:0]           in_res,
  output ctl_t                            out_ctl,
  output logic      [TAPS-1:0][PIX_W-1:0] out_vals,
  output logic      [TAPS-1:0]            out_mask,
  output logic      [KW-1:0]              out_k,
  output logic      [PIX_W-1:0]           out_res
);

  logic [TAPS-1:0] plane;
  logic [TAPS-1:0] zeros;
  logic [KW-1:0]   c0;
  logic [TAPS-1:0] mask_nxt;
  logic [KW-1:0]   k_nxt;
  logic [PIX_W-1:0] res_nxt;

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      plane[i] = in_vals[i][BIT];
    end
    zeros   = in_mask & ~plane;
    c0      = KW'($countones(zeros));
    res_nxt = in_res;
    // rank falls among the candidates with a zero here: keep those
    if (in_k < c0) begin
      res_nxt[BIT] = 1'b0;
      mask_nxt     = zeros;
      k_nxt        = in_k;
    end else begin
      res_nxt[BIT] = 1'b1;
      mask_nxt     = in_mask & plane;
      k_nxt        = in_k - c0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
    out_vals <= in_vals;
    out_mask <= mask_nxt;
    out_k    <= k_nxt;
    out_res  <= res_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/median_filter_5x5.sv -----
// Median filter top level: position counters, line stores, window, select chain,
// output queue. Depends on mf_pkg, mf_line_store, mf_select_cell.
//
// Usage:
//   Input channel (in_valid / in_stall): one grey pixel per item in raster order;
//   in_frame_start marks the first pixel of a frame and restarts the position.
//   Output channel (out_valid / out_stall): one median per pixel whose full
//   window lies inside the frame; out_frame_end marks the frame's last one.
//   Config (cfg_valid / cfg_ready, always ready): index 0 line width,
//   index 1 frame height. Write only while the block is idle.
// Throughput: one pixel per cycle while in_stall is low, set by the select chain
//   which takes a new window every cycle (one cell per result bit).
// Path: a result passes the read stage (loaded at the pixel's accepting edge),
//   then the window register, 8 select cells and the queue before out_valid rises.
// Stall: results wait in a 16-entry queue; in_stall rises only when the queue
//   plus items in flight would fill it, so pixels keep flowing meanwhile.
// Reset: counters, queue and window clear; line stores are not cleared and
//   need not be, as no output depends on stale lines.
`default_nettype none
module median_filter_5x5
  import mf_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int WINDOW_SIZE = DEF_WIN_SIZE
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_W-1:0]      in_pixel,
  input  wire logic                  in_frame_start,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [PIX_W-1:0]      out_median_value,
  output logic                       out_frame_end,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LINES = WINDOW_SIZE - 1;
  localparam int TAPS  = WINDOW_SIZE * WINDOW_SIZE;
  localparam int KW    = $clog2(TAPS + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW + 1;
  localparam int FAW   = $clog2(OUT_FIFO_D);
  localparam int PW    = FAW + 1;

  // configuration
  logic [LW_W-1:0] cfg_lw_r;
  logic [FH_W-1:0] cfg_fh_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_lw_r <= LW_RESET;
      cfg_fh_r <= FH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:   cfg_lw_r <= cfg_data[LW_W-1:0];
        REG_FRAME_HEIGHT: cfg_fh_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [31:0]     w32;
  logic [WW-1:0]   w_use;
  logic [FH_W-1:0] h_use;

  always_comb begin
    w32 = 32'(cfg_lw_r);
    if (w32 < 32'(WINDOW_SIZE)) w32 = 32'(WINDOW_SIZE);
    if (w32 > 32'(MAX_WIDTH))   w32 = 32'(MAX_WIDTH);
    w_use = WW'(w32);
    h_use = (cfg_fh_r < FH_W'(WINDOW_SIZE)) ? FH_W'(WINDOW_SIZE) : cfg_fh_r;
  end

  // position counters, stage 0
  logic [CW-1:0]   col_r, col_nxt, col_a, col_e;
  logic [FH_W-1:0] row_r, row_nxt, row_a, row_e;
  logic [WW-1:0]   col_inc;
  logic [FH_W:0]   row_inc;
  logic            emit, last, accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    col_a   = in_frame_start ? '0 : col_r;
    row_a   = in_frame_start ? '0 : row_r;
    col_e   = ({1'b0, col_a} >= w_use) ? '0 : col_a;
    row_e   = (row_a >= h_use) ? '0 : row_a;
    col_inc = {1'b0, col_e} + WW'(1);
    row_inc = {1'b0, row_e} + (FH_W+1)'(1);
    emit    = (32'(row_e) >= 32'(LINES)) && (32'(col_e) >= 32'(LINES));
    last    = (row_inc == {1'b0, h_use}) && (col_inc == w_use);
    if (col_inc >= w_use) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, h_use}) ? '0 : row_inc[FH_W-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line store data arrives, stores written, window shifted
  logic             v1_r;
  logic             emit1_r, last1_r;
  logic [CW-1:0]    col1_r;
  logic [PIX_W-1:0] px1_r;
  logic [PIX_W-1:0] rd [LINES];
  logic [PIX_W-1:0] column [WINDOW_SIZE];
  logic             byp_r;
  logic [PIX_W-1:0] byp_col_r [LINES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      byp_r <= 1'b0;
    end else begin
      v1_r  <= accept;
      // next item reads the column being written now: forward the write data
      byp_r <= v1_r && (col1_r == col_e);
    end
    emit1_r <= emit;
    last1_r <= last;
    col1_r  <= col_e;
    px1_r   <= in_pixel;
    for (int k = 0; k < LINES; k++) begin
      byp_col_r[k] <= column[k];
    end
  end

  always_comb begin
    column[0] = px1_r;
    for (int k = 1; k < WINDOW_SIZE; k++) begin
      column[k] = byp_r ? byp_col_r[k-1] : rd[k-1];
    end
  end

  for (genvar g = 0; g < LINES; g++) begin : g_line
    mf_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
    ) u_store (
      .clk     (clk),
      .rd_addr (col_e),
      .rd_data (rd[g]),
      .wr_en   (v1_r),
      .wr_addr (col1_r),
      .wr_data (column[g])
    );
  end

  logic [WINDOW_SIZE-1:0][WINDOW_SIZE-1:0][PIX_W-1:0] win_r;
  ctl_t                                               ctl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      ctl2_r <= '0;
    end else begin
      ctl2_r.valid <= v1_r && emit1_r;
      ctl2_r.last  <= last1_r;
      if (v1_r) begin
        for (int r = 0; r < WINDOW_SIZE; r++) begin
          for (int c = 0; c < WINDOW_SIZE - 1; c++) begin
            win_r[r][c] <= win_r[r][c+1];
          end
          win_r[r][WINDOW_SIZE-1] <= column[WINDOW_SIZE-1-r];
        end
      end
    end
  end

  // select chain, one cell per bit
  ctl_t                       s_ctl  [PIX_W+1];
  logic [TAPS-1:0][PIX_W-1:0] s_vals [PIX_W+1];
  logic [TAPS-1:0]            s_mask [PIX_W+1];
  logic [KW-1:0]              s_k    [PIX_W+1];
  logic [PIX_W-1:0]           s_res  [PIX_W+1];

  always_comb begin
    s_ctl[0] = ctl2_r;
    for (int r = 0; r < WINDOW_SIZE; r++) begin
      for (int c = 0; c < WINDOW_SIZE; c++) begin
        s_vals[0][r*WINDOW_SIZE + c] = win_r[r][c];
      end
    end
    s_mask[0] = '1;
    s_k[0]    = KW'(TAPS / 2);
    s_res[0]  = '0;
  end

  for (genvar g = 0; g < PIX_W; g++) begin : g_cell
    mf_select_cell #(
      .TAPS (TAPS),
      .KW   (KW),
      .BIT  (PIX_W - 1 - g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_ctl   (s_ctl[g]),
      .in_vals  (s_vals[g]),
      .in_mask  (s_mask[g]),
      .in_k     (s_k[g]),
      .in_res   (s_res[g]),
      .out_ctl  (s_ctl[g+1]),
      .out_vals (s_vals[g+1]),
      .out_mask (s_mask[g+1]),
      .out_k    (s_k[g+1]),
      .out_res  (s_res[g+1])
    );
  end

  // output queue with credit count of items in flight
  res_t           fifo_r [OUT_FIFO_D];
  logic [FAW-1:0] wp_r, rp_r;
  logic [PW-1:0]  cnt_r, pend_r;
  logic           push, pop;
  res_t           head;

  assign push      = s_ctl[PIX_W].valid;
  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign head      = fifo_r[rp_r];
  assign out_median_value = head.median;
  assign out_frame_end    = head.last;
  assign in_stall  = (pend_r >= PW'(OUT_FIFO_D));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      pend_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + FAW'(1);
      if (pop)  rp_r <= rp_r + FAW'(1);
      cnt_r  <= cnt_r + PW'(push) - PW'(pop);
      pend_r <= pend_r + PW'(accept && emit) - PW'(pop);
    end
    if (push) begin
      fifo_r[wp_r].median <= s_res[PIX_W];
      fifo_r[wp_r].last   <= s_ctl[PIX_W].last;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mf_checker.sv -----
// Port-level checks for median_filter_5x5, bound to the top level.
// Depends on mf_pkg for field widths.
`default_nettype none
module mf_checker
  import mf_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [PIX_W-1:0] out_median_value,
  input wire logic             out_frame_end
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_median_value) && $stable(out_frame_end))
    else $error("result changed while stalled");

  // reset empties the queue and frees the input
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind median_filter_5x5 mf_checker u_mf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_median_value (out_median_value),
  .out_frame_end    (out_frame_end)
);
`default_nettype wire

// ----- bench/median_check.sv -----
// Watches the pixel, median and config channels of median_filter_5x5, predicts
// each median and compares it with the block's output. Depends on mf_pkg.
`timescale 1ns / 1ps
module median_check
  import mf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic                  in_frame_start,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [PIX_W-1:0]      out_median_value,
  input  logic                  out_frame_end,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int ROWS_BACK = DEF_WIN_SIZE - 1;

  logic [PIX_W-1:0] prev_lines [ROWS_BACK][DEF_MAX_WIDTH];
  logic [PIX_W-1:0] win [DEF_WIN_SIZE][DEF_WIN_SIZE];
  int unsigned      col_pos, row_pos;
  logic [LW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  res_t             medians_due[$];
  int               fails;

  initial begin
    fails = 0;
    fail_count = 0;
    pending = 0;
    for (int k = 0; k < ROWS_BACK; k++)
      for (int c = 0; c < DEF_MAX_WIDTH; c++) prev_lines[k][c] = '0;
  end

  function automatic logic [PIX_W-1:0] window_median();
    logic [PIX_W-1:0] v[25];
    logic [PIX_W-1:0] x;
    int j;
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++) v[r*5+c] = win[r][c];
    for (int i = 1; i < 25; i++) begin
      x = v[i];
      j = i;
      while (j > 0 && v[j-1] > x) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = x;
    end
    return v[12];
  endfunction

  task automatic predict_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned w, h, c;
    logic [PIX_W-1:0] newcol[DEF_WIN_SIZE];
    res_t res;
    w = width_reg;
    if (w < 5) w = 5;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    h = height_reg;
    if (h < 5) h = 5;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    newcol[0] = px;
    for (int k = 1; k <= ROWS_BACK; k++) newcol[k] = prev_lines[k-1][c];
    for (int k = ROWS_BACK; k >= 1; k--) prev_lines[k-1][c] = newcol[k-1];
    for (int r = 0; r < 5; r++) begin
      for (int q = 0; q < 4; q++) win[r][q] = win[r][q+1];
      win[r][4] = newcol[4-r];
    end
    if (row_pos >= ROWS_BACK && c >= ROWS_BACK) begin
      res.median = window_median();
      res.last   = (row_pos + 1 == h) && (c + 1 == w);
      medians_due.push_back(res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      for (int r = 0; r < 5; r++)
        for (int q = 0; q < 5; q++) win[r][q] = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = LW_RESET;
      height_reg = FH_RESET;
      medians_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (medians_due.size() == 0) begin
          $display("%0t: unexpected median %0d frame_end %0b", $time,
                   out_median_value, out_frame_end);
          fails++;
        end else begin
          want = medians_due.pop_front();
          if (want.median !== out_median_value) begin
            $display("%0t: median expected %0d actual %0d", $time, want.median,
                     out_median_value);
            fails++;
          end
          if (want.last !== out_frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b", $time, want.last,
                     out_frame_end);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LINE_WIDTH) width_reg = cfg_data[LW_W-1:0];
        else if (cfg_index == REG_FRAME_HEIGHT) height_reg = cfg_data[FH_W-1:0];
      end
      if (in_valid && !in_stall) predict_pixel(in_pixel, in_frame_start);
    end
    pending <= medians_due.size();
    fail_count <= fails + medians_due.size() * 0;
  end

endmodule

// ----- bench/tb.sv -----
// Top of the median filter bench: clock, reset, pixel and config stimulus,
// output stall pattern and verdict. Depends on mf_pkg, median_check, the RTL.
`timescale 1ns / 1ps
module tb;
  import mf_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 800;
  localparam int WIDE_ITEMS = 200;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_median_value;
  logic                  out_frame_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count, pending;
  int                    cycles = 0;
  int                    burst_left = 0;
  int                    stall_left = 0;
  int                    stall_mode = 0;

  always #5 clk = ~clk;

  median_filter_5x5 i_dut (.*);

  median_check i_check (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall pattern: phases of none, light, heavy and near-total stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // drain all medians, then give the pipeline time to finish pixels with none
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input int mode, input int base);
    case (mode)
      0: return PIX_W'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return PIX_W'(base + $urandom_range(0, 6));
    endcase
  endfunction

  initial begin
    int sent, n, mode, base;
    logic [CFG_DATA_W-1:0] wv, hv;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest frame, reached by clamping: one median per frame
    write_reg(REG_LINE_WIDTH, 16'h0000);
    write_reg(REG_FRAME_HEIGHT, 16'h0000);
    for (int i = 0; i < 25; i++) send_pixel(PIX_W'(250 - i * 10), i == 0);
    for (int i = 0; i < 7; i++) send_pixel(8'hFF, 1'b0);
    // restart in mid-frame, then a second frame by wrap alone
    for (int i = 0; i < 50; i++) send_pixel((i % 2) ? 8'hFF : 8'h00, i == 0);
    settle();

    // widest line, tallest frame; unused indexes must be ignored
    write_reg(REG_LINE_WIDTH, 16'hFFFF);
    write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    write_reg(CFG_IDX_W'(2), 16'($urandom));
    write_reg(CFG_IDX_W'(3), 16'($urandom));
    for (int i = 0; i < WIDE_ITEMS; i++)
      send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
    settle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: wv = 16'($urandom);
        1: wv = {4'($urandom), 12'($urandom_range(0, 4))};
        default: wv = 16'($urandom_range(5, 12));
      endcase
      if (wv[11:0] > 12'd40) wv[11:0] = 12'($urandom_range(5, 12)) | 12'h800;
      case ($urandom_range(0, 7))
        0: hv = 16'hFFFF;
        1: hv = 16'($urandom_range(0, 4));
        default: hv = 16'($urandom_range(5, 9));
      endcase
      write_reg(REG_LINE_WIDTH, wv);
      write_reg(REG_FRAME_HEIGHT, hv);
      mode = $urandom_range(0, 2);
      base = $urandom_range(0, 249);
      n = $urandom_range(40, 200);
      for (int i = 0; i < n; i++)
        send_pixel(pick_pixel(mode, base), i == 0 || $urandom_range(0, 99) == 0);
      sent += n;
      settle();
    end

    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
